@@ rtl/tlpq_pkg.sv @@
package tlpq_pkg;

    localparam int LEVELS = 3;

    localparam logic [1:0] ACT_ENQUEUE = 2'd0;
    localparam logic [1:0] ACT_DEQUEUE = 2'd1;
    localparam logic [1:0] ACT_CLEAR   = 2'd2;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_OVERFLOW  = 2'd1;
    localparam logic [1:0] STAT_UNDERFLOW = 2'd2;

    localparam logic [1:0] LEVEL_NONE = 2'd0;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] item;
        logic [1:0] priority_req;
    } request_t;

    typedef struct packed {
        logic [7:0] out_item;
        logic [1:0] served_level;
        logic [1:0] status;
        logic [2:0] empty_flags;
        logic [2:0] full_flags;
    } result_t;

    typedef struct packed {
        logic load;
        logic exec;
    } cmd_t;

endpackage

@@ rtl/tlpq_ram.sv @@
module tlpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/tlpq_ctrl.sv @@
module tlpq_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    output logic            done,
    output tlpq_pkg::cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } state_t;

    state_t state_reg;
    logic   busy_reg;
    logic   done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    done_reg <= 1'b0;
                    if (start)
                    begin
                        state_reg <= S_EXEC;
                        busy_reg  <= 1'b1;
                    end
                end
                S_EXEC:
                begin
                    state_reg <= S_RESP;
                    done_reg  <= 1'b1;
                end
                S_RESP:
                begin
                    state_reg <= S_IDLE;
                    busy_reg  <= 1'b0;
                    done_reg  <= 1'b0;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                    busy_reg  <= 1'b0;
                    done_reg  <= 1'b0;
                end
            endcase
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign cmd.load = start && !busy_reg;
    assign cmd.exec = (state_reg == S_EXEC);

endmodule

@@ rtl/tlpq_datapath.sv @@
module tlpq_datapath #(
    parameter int SLOTS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tlpq_pkg::cmd_t      cmd,
    input  tlpq_pkg::request_t  request,
    output tlpq_pkg::result_t   result
);

    localparam int PTR_W = $clog2(SLOTS);
    localparam int LV    = tlpq_pkg::LEVELS;

    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] n;
        if (p == PTR_W'(SLOTS - 1))
        begin
            n = '0;
        end
        else
        begin
            n = p + PTR_W'(1);
        end
        return n;
    endfunction

    tlpq_pkg::request_t op_reg;

    logic [PTR_W-1:0] head_reg  [LV];
    logic [PTR_W-1:0] tail_reg  [LV];
    logic [PTR_W-1:0] head_next [LV];
    logic [PTR_W-1:0] tail_next [LV];

    logic [1:0]   served_reg;
    logic [1:0]   served_next;
    logic [1:0]   status_reg;
    logic [1:0]   status_next;
    logic [LV-1:0] empty_reg;
    logic [LV-1:0] empty_next;
    logic [LV-1:0] full_reg;
    logic [LV-1:0] full_next;
    logic         deq_ok_reg;
    logic         deq_ok_next;
    logic [1:0]   sel_reg;
    logic [1:0]   sel_next;

    logic [LV-1:0] empty_cur;
    logic [LV-1:0] full_cur;
    logic [LV-1:0] wr_en;
    logic [1:0]    q_enq;
    logic [7:0]    rd_data [LV];

    always_comb
    begin
        for (int q = 0; q < LV; q++)
        begin
            empty_cur[q] = (head_reg[q] == tail_reg[q]);
            full_cur[q]  = (advance(tail_reg[q]) == head_reg[q]);
            head_next[q] = head_reg[q];
            tail_next[q] = tail_reg[q];
        end

        if (op_reg.priority_req == 2'd1)
        begin
            q_enq = 2'd0;
        end
        else if (op_reg.priority_req == 2'd2)
        begin
            q_enq = 2'd1;
        end
        else
        begin
            q_enq = 2'd2;
        end

        wr_en       = '0;
        served_next = tlpq_pkg::LEVEL_NONE;
        status_next = tlpq_pkg::STAT_OK;
        deq_ok_next = 1'b0;
        sel_next    = 2'd0;

        case (op_reg.action)
            tlpq_pkg::ACT_ENQUEUE:
            begin
                if (full_cur[q_enq])
                begin
                    status_next = tlpq_pkg::STAT_OVERFLOW;
                end
                else
                begin
                    wr_en[q_enq]     = 1'b1;
                    tail_next[q_enq] = advance(tail_reg[q_enq]);
                    served_next      = q_enq + 2'd1;
                end
            end
            tlpq_pkg::ACT_DEQUEUE:
            begin
                if (!empty_cur[0])
                begin
                    sel_next    = 2'd0;
                    deq_ok_next = 1'b1;
                end
                else if (!empty_cur[1])
                begin
                    sel_next    = 2'd1;
                    deq_ok_next = 1'b1;
                end
                else if (!empty_cur[2])
                begin
                    sel_next    = 2'd2;
                    deq_ok_next = 1'b1;
                end
                if (deq_ok_next)
                begin
                    head_next[sel_next] = advance(head_reg[sel_next]);
                    served_next         = sel_next + 2'd1;
                end
                else
                begin
                    status_next = tlpq_pkg::STAT_UNDERFLOW;
                end
            end
            tlpq_pkg::ACT_CLEAR:
            begin
                for (int q = 0; q < LV; q++)
                begin
                    head_next[q] = tail_reg[q];
                end
            end
            default:
            begin
            end
        endcase

        for (int q = 0; q < LV; q++)
        begin
            empty_next[q] = (head_next[q] == tail_next[q]);
            full_next[q]  = (advance(tail_next[q]) == head_next[q]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int q = 0; q < LV; q++)
            begin
                head_reg[q] <= '0;
                tail_reg[q] <= '0;
            end
        end
        else if (cmd.exec)
        begin
            for (int q = 0; q < LV; q++)
            begin
                head_reg[q] <= head_next[q];
                tail_reg[q] <= tail_next[q];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= request;
        end
        if (cmd.exec)
        begin
            served_reg <= served_next;
            status_reg <= status_next;
            empty_reg  <= empty_next;
            full_reg   <= full_next;
            deq_ok_reg <= deq_ok_next;
            sel_reg    <= sel_next;
        end
    end

    // one slot memory per level, read continuously at its head
    for (genvar l = 0; l < LV; l++)
    begin : g_level
        tlpq_ram #(
            .WIDTH (8),
            .DEPTH (SLOTS)
        ) u_ram (
            .clk   (clk),
            .we    (cmd.exec && wr_en[l]),
            .waddr (tail_reg[l]),
            .wdata (op_reg.item),
            .raddr (head_reg[l]),
            .rdata (rd_data[l])
        );
    end

    assign result.out_item     = deq_ok_reg ? rd_data[sel_reg] : 8'd0;
    assign result.served_level = served_reg;
    assign result.status       = status_reg;
    assign result.empty_flags  = empty_reg;
    assign result.full_flags   = full_reg;

endmodule

@@ rtl/three_level_priority_queue_top.sv @@
// a result strobes on done after the start transfer, registered in the execute state
// a new start is taken only once idle again; steps: accept, pointer update
// and slot access, slot read data registered out of the level memory
// reset: rst_n asynchronous active low; all queues empty, block idle
// the receiver cannot stall; each result is valid for the single done cycle
module three_level_priority_queue_top #(
    parameter int SLOTS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  tlpq_pkg::request_t  request,
    output logic                done,
    output tlpq_pkg::result_t   result
);

    tlpq_pkg::cmd_t cmd;

    tlpq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    tlpq_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .request (request),
        .result  (result)
    );

    a_start_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##2 done)
        else $error("result did not follow a start transfer");

    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy && !done)
        else $error("busy not raised after start transfer");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy ##1 !done)
        else $error("done strobe longer than one cycle or outside busy");

    a_error_no_level: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status != tlpq_pkg::STAT_OK |->
            result.served_level == tlpq_pkg::LEVEL_NONE && result.out_item == 8'd0)
        else $error("failed operation reports a served level or item");

endmodule
